// File: hdl/rmoe_pkg.sv
// ----------------------------------------------------------------------------
// rmoe_pkg - shared definitions for the register machine op executor
// Opcodes, the decoded op kinds, the queue entry layout and the sizing
// defaults used by the front end, the queue and the execution back end.
// ----------------------------------------------------------------------------
package rmoe_pkg;

	// Sizing defaults, used as the defaults of the top level parameters.
	localparam int NUM_REGS_DEFAULT    = 32;
	localparam int MEM_WORDS_DEFAULT   = 4096;
	localparam int QUEUE_DEPTH_DEFAULT = 4;

	// Fixed field and datapath widths.
	localparam int FIELD_W   = 8;
	localparam int DATA_W    = 64;
	localparam int USER_W    = 3;
	localparam int IMM_W     = 16;
	localparam int SHIFT_W   = 6;
	localparam int IMM_SHIFT = 8;

	// Multiplier of the hash call.
	localparam logic [31:0] HASH_MUL = 32'd2654435761;

	// Opcodes as they arrive on the input stream.
	localparam logic [FIELD_W-1:0] OP_MOV  = 8'd0;
	localparam logic [FIELD_W-1:0] OP_ADD  = 8'd1;
	localparam logic [FIELD_W-1:0] OP_SUB  = 8'd2;
	localparam logic [FIELD_W-1:0] OP_AND  = 8'd3;
	localparam logic [FIELD_W-1:0] OP_OR   = 8'd4;
	localparam logic [FIELD_W-1:0] OP_XOR  = 8'd5;
	localparam logic [FIELD_W-1:0] OP_SHL  = 8'd6;
	localparam logic [FIELD_W-1:0] OP_SHR  = 8'd7;
	localparam logic [FIELD_W-1:0] OP_MOVI = 8'd8;
	localparam logic [FIELD_W-1:0] OP_LD   = 8'd9;
	localparam logic [FIELD_W-1:0] OP_ST   = 8'd10;
	localparam logic [FIELD_W-1:0] OP_BR   = 8'd11;
	localparam logic [FIELD_W-1:0] OP_SET  = 8'd12;
	localparam logic [FIELD_W-1:0] OP_CALL = 8'd13;
	localparam logic [FIELD_W-1:0] OP_EXIT = 8'd14;

	// Bit positions of the result flags on the output tuser.
	localparam int USER_EXITED  = 0;
	localparam int USER_SKIPPED = 1;
	localparam int USER_BAD     = 2;

	// Classified op, as the front end hands it to the back end.
	typedef enum logic [3:0] {
		K_MOV, K_ADD, K_SUB, K_AND, K_OR, K_XOR, K_SHL, K_SHR,
		K_MOVI, K_LD, K_ST, K_BR, K_SET, K_CALL, K_EXIT, K_BAD
	} op_kind_t;

	// Register indices are already reduced to the register file depth;
	// rs is read port A and rb read port B.
	typedef struct packed {
		op_kind_t             kind;
		logic [FIELD_W-1:0]   rd;
		logic [FIELD_W-1:0]   rs;
		logic [FIELD_W-1:0]   rb;
		logic [IMM_W-1:0]     imm;
	} op_t;

endpackage

// File: hdl/register_machine_op_executor.sv
// ----------------------------------------------------------------------------
// register_machine_op_executor - four-byte op executor with register file
// Executes one op per input transaction against a 64-bit register file and
// a 64-bit data memory, and returns one result transaction per op.
// ----------------------------------------------------------------------------
//
// Channel   Direction  tdata                             tuser
// s_axis    in         cmd, dest_field, src_field, aux   -
// m_axis    out        exit_value                        exited, was_skipped, bad_opcode
//
// Cycles: one op per cycle sustained when the output does not stall. An op
// that reads the result of the load or call directly ahead of it waits at
// the queue head while that op is in stage 2, as the load data leaves the
// data memory read port and the hash product completes only in the third
// back end stage. A result is presented from the result register, after
// the op queue and back end stages 2 and 3.
// Reset: a clearing pass writes zero to every data memory word, one word a
// cycle; s_axis_tready stays low until it ends.
// Stalls: a stalled output freezes the back end; the op queue of
// QUEUE_DEPTH entries keeps accepting input until it fills.
//
// MEM_WORDS must be a power of two; NUM_REGS may take any value in range.
//
module register_machine_op_executor import rmoe_pkg::*; #(
	parameter int NUM_REGS    = NUM_REGS_DEFAULT,
	parameter int MEM_WORDS   = MEM_WORDS_DEFAULT,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	// [7:0] cmd, [15:8] dest_field, [23:16] src_field, [31:24] aux_field
	input  logic [31:0]       s_axis_tdata,
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	// [63:0] exit_value
	output logic [DATA_W-1:0] m_axis_tdata,
	// [0] exited, [1] was_skipped, [2] bad_opcode
	output logic [USER_W-1:0] m_axis_tuser
);

	localparam int RW = $clog2(NUM_REGS);

	op_t               dec_op, head_op;
	logic              q_full, push, pop, head_valid, busy;
	logic              rf_rd_en, rf_we;
	logic [RW-1:0]     rf_addr_a, rf_addr_b, rf_waddr;
	logic [DATA_W-1:0] rf_data_a, rf_data_b, rf_wdata;

	// Front end: classify the op and queue it. Input is held off while the
	// queue is full or the data memory is still being cleared.
	assign s_axis_tready = !q_full && !busy;
	assign push          = s_axis_tvalid && s_axis_tready;

	rmoe_decode #(
		.NUM_REGS (NUM_REGS)
	) u_decode (
		.cmd        (s_axis_tdata[7:0]),
		.dest_field (s_axis_tdata[15:8]),
		.src_field  (s_axis_tdata[23:16]),
		.aux_field  (s_axis_tdata[31:24]),
		.op         (dec_op)
	);

	rmoe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (dec_op),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op)
	);

	// Register file, read when an op issues from the queue head and written
	// back from the third back end stage.
	rmoe_regfile #(
		.NUM_REGS (NUM_REGS)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rf_rd_en),
		.rd_addr_a (rf_addr_a),
		.rd_addr_b (rf_addr_b),
		.rd_data_a (rf_data_a),
		.rd_data_b (rf_data_b),
		.wr_en     (rf_we),
		.wr_addr   (rf_waddr),
		.wr_data   (rf_wdata)
	);

	// Back end: issue, execute, write back and present the result.
	rmoe_execute #(
		.NUM_REGS  (NUM_REGS),
		.MEM_WORDS (MEM_WORDS)
	) u_execute (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (pop),
		.rf_rd_en   (rf_rd_en),
		.rf_addr_a  (rf_addr_a),
		.rf_addr_b  (rf_addr_b),
		.rf_data_a  (rf_data_a),
		.rf_data_b  (rf_data_b),
		.rf_we      (rf_we),
		.rf_waddr   (rf_waddr),
		.rf_wdata   (rf_wdata),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_data   (m_axis_tdata),
		.res_user   (m_axis_tuser),
		.busy       (busy)
	);

endmodule

// File: hdl/rmoe_decode.sv
// ----------------------------------------------------------------------------
// rmoe_decode - op classifier of the front end
// Turns the four op bytes into an op kind, reduced register indices and
// the read port addresses that the back end needs.
// ----------------------------------------------------------------------------
module rmoe_decode import rmoe_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
	input  logic [FIELD_W-1:0] cmd,
	input  logic [FIELD_W-1:0] dest_field,
	input  logic [FIELD_W-1:0] src_field,
	input  logic [FIELD_W-1:0] aux_field,
	output op_t                op
);

	// Field modulo NUM_REGS by reciprocal multiplication; the quotient
	// estimate is at most one low, so one conditional subtract finishes it.
	localparam logic [15:0] RECIP = 16'((1 << 16) / NUM_REGS);
	localparam logic [8:0]  NREG  = 9'(NUM_REGS);

	function automatic logic [FIELD_W-1:0] reg_index(input logic [FIELD_W-1:0] field);
		logic [23:0]        prod;
		logic [7:0]         quot;
		logic [16:0]        qn;
		logic [FIELD_W-1:0] rem;
		prod = field * RECIP;
		quot = prod[23:16];
		qn   = quot * NREG;
		rem  = field - qn[7:0];
		if ({1'b0, rem} >= NREG) begin
			rem = rem - NREG[7:0];
		end
		return rem;
	endfunction

	logic [FIELD_W-1:0] rd_idx, rs_idx, ra_idx;

	always_comb begin
		rd_idx  = reg_index(dest_field);
		rs_idx  = reg_index(src_field);
		ra_idx  = reg_index(aux_field);
		op.rd   = rd_idx;
		op.rs   = rs_idx;
		op.rb   = ra_idx;
		op.imm  = (IMM_W'(src_field) << IMM_SHIFT) | IMM_W'(aux_field);
		unique case (cmd)
			OP_MOV:  op.kind = K_MOV;
			OP_ADD:  op.kind = K_ADD;
			OP_SUB:  op.kind = K_SUB;
			OP_AND:  op.kind = K_AND;
			OP_OR:   op.kind = K_OR;
			OP_XOR:  op.kind = K_XOR;
			OP_SHL:  op.kind = K_SHL;
			OP_SHR:  op.kind = K_SHR;
			OP_MOVI: op.kind = K_MOVI;
			OP_LD:   op.kind = K_LD;
			OP_ST: begin
				// The store data comes from the destination register.
				op.kind = K_ST;
				op.rb   = rd_idx;
			end
			OP_BR:   op.kind = K_BR;
			OP_SET:  op.kind = K_SET;
			OP_CALL: op.kind = K_CALL;
			OP_EXIT: begin
				// Exit reads register zero, which is added to the op count.
				op.kind = K_EXIT;
				op.rs   = '0;
			end
			default: op.kind = K_BAD;
		endcase
	end

endmodule

// File: hdl/rmoe_queue.sv
// ----------------------------------------------------------------------------
// rmoe_queue - op queue between front end and back end
// A small first-in first-out buffer of classified ops; the head entry is
// the issue slot of the back end.
// ----------------------------------------------------------------------------
module rmoe_queue import rmoe_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output op_t  head_op
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	op_t           entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full       = (count_q == FULLC);
	assign head_valid = (count_q != '0);
	assign head_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// File: hdl/rmoe_regfile.sv
// ----------------------------------------------------------------------------
// rmoe_regfile - register file of the executor
// One write port, two read ports with registered read data. A read at the
// edge of a write to the same entry returns the new value. Entries never
// written read as their reset value, tracked by one valid bit per entry.
// ----------------------------------------------------------------------------
module rmoe_regfile import rmoe_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [$clog2(NUM_REGS)-1:0] rd_addr_a,
	input  logic [$clog2(NUM_REGS)-1:0] rd_addr_b,
	output logic [DATA_W-1:0]           rd_data_a,
	output logic [DATA_W-1:0]           rd_data_b,
	input  logic                        wr_en,
	input  logic [$clog2(NUM_REGS)-1:0] wr_addr,
	input  logic [DATA_W-1:0]           wr_data
);

	localparam int RW = $clog2(NUM_REGS);

	// Entry i comes out of reset holding i*7+1.
	function automatic logic [DATA_W-1:0] reset_value(input logic [RW-1:0] idx);
		logic [10:0] ext;
		ext = 11'(idx);
		return DATA_W'((ext << 3) - ext + 11'd1);
	endfunction

	logic [DATA_W-1:0]   mem [NUM_REGS];
	logic [NUM_REGS-1:0] valid_q;
	logic [DATA_W-1:0]   raw_a_q, raw_b_q;
	logic                vld_a_q, vld_b_q;
	logic [RW-1:0]       addr_a_q, addr_b_q;
	logic                hit_a, hit_b;

	assign hit_a = wr_en && (wr_addr == rd_addr_a);
	assign hit_b = wr_en && (wr_addr == rd_addr_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			raw_a_q  <= hit_a ? wr_data : mem[rd_addr_a];
			raw_b_q  <= hit_b ? wr_data : mem[rd_addr_b];
			vld_a_q  <= hit_a || valid_q[rd_addr_a];
			vld_b_q  <= hit_b || valid_q[rd_addr_b];
			addr_a_q <= rd_addr_a;
			addr_b_q <= rd_addr_b;
		end
	end

	assign rd_data_a = vld_a_q ? raw_a_q : reset_value(addr_a_q);
	assign rd_data_b = vld_b_q ? raw_b_q : reset_value(addr_b_q);

endmodule

// File: hdl/rmoe_execute.sv
// ----------------------------------------------------------------------------
// rmoe_execute - execution back end
// Issues ops from the queue head, executes them with operand forwarding,
// owns the data memory, the op counter and the branch skip flag, and holds
// the result register of the output stream.
// ----------------------------------------------------------------------------
module rmoe_execute import rmoe_pkg::*; #(
	parameter int NUM_REGS  = NUM_REGS_DEFAULT,
	parameter int MEM_WORDS = MEM_WORDS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        head_valid,
	input  op_t                         head_op,
	output logic                        pop,
	output logic                        rf_rd_en,
	output logic [$clog2(NUM_REGS)-1:0] rf_addr_a,
	output logic [$clog2(NUM_REGS)-1:0] rf_addr_b,
	input  logic [DATA_W-1:0]           rf_data_a,
	input  logic [DATA_W-1:0]           rf_data_b,
	output logic                        rf_we,
	output logic [$clog2(NUM_REGS)-1:0] rf_waddr,
	output logic [DATA_W-1:0]           rf_wdata,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [DATA_W-1:0]           res_data,
	output logic [USER_W-1:0]           res_user,
	output logic                        busy
);

	localparam int RW = $clog2(NUM_REGS);
	localparam int AW = $clog2(MEM_WORDS);
	localparam logic [AW-1:0] MEM_LAST = AW'(MEM_WORDS - 1);

	typedef enum logic [1:0] {SEL_ALU, SEL_LOAD, SEL_HASH} res_sel_t;

	// Stage 2: operands and execution.
	logic               valid_s2;
	op_t                op_s2;
	// Stage 3: load data, hash completion, write-back.
	logic               valid_s3, wr_s3, exited_s3, skipped_s3, bad_s3;
	res_sel_t           sel_s3;
	logic [FIELD_W-1:0] rd_s3;
	logic [DATA_W-1:0]  alu_s3, plo_s3, mrd_s3;
	logic [31:0]        phi_s3;
	// Result register.
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;
	logic [USER_W-1:0]  out_user_q;
	// Architectural state.
	logic               skip_q;
	logic [DATA_W-1:0]  op_count_q;
	logic               clr_busy_q;
	logic [AW-1:0]      clr_addr_q;

	logic               adv, hazard, fwd_a, fwd_b, exec_s2, wr_s2, st_fire, ld_fire;
	logic [DATA_W-1:0]  opa, opb, alu, plo, hash_s3;
	logic [31:0]        phi;
	res_sel_t           sel_s2;
	logic [AW-1:0]      mem_addr;
	logic [SHIFT_W-1:0] shamt;

	logic [DATA_W-1:0]  dmem [MEM_WORDS];

	// The whole back end moves together whenever the result register frees.
	assign adv = !out_valid_q || res_ready;

	// A load or hash result is only known in stage 3, too late to forward
	// into stage 2: a dependent op waits at the queue head until the load or call leaves stage 2.
	assign hazard = valid_s2 && (op_s2.kind == K_LD || op_s2.kind == K_CALL)
		&& (op_s2.rd == head_op.rs || op_s2.rd == head_op.rb);
	assign pop       = adv && head_valid && !hazard && !clr_busy_q;
	assign rf_rd_en  = pop;
	assign rf_addr_a = head_op.rs[RW-1:0];
	assign rf_addr_b = head_op.rb[RW-1:0];

	assign fwd_a = valid_s3 && wr_s3 && (sel_s3 == SEL_ALU) && (rd_s3 == op_s2.rs);
	assign fwd_b = valid_s3 && wr_s3 && (sel_s3 == SEL_ALU) && (rd_s3 == op_s2.rb);
	assign opa   = fwd_a ? alu_s3 : rf_data_a;
	assign opb   = fwd_b ? alu_s3 : rf_data_b;

	assign exec_s2 = valid_s2 && !skip_q;
	assign shamt   = opb[SHIFT_W-1:0];

	always_comb begin
		case (op_s2.kind)
			K_MOV:   alu = opa;
			K_ADD:   alu = opa + opb;
			K_SUB:   alu = opa - opb;
			K_AND:   alu = opa & opb;
			K_OR:    alu = opa | opb;
			K_XOR:   alu = opa ^ opb;
			K_SHL:   alu = opa << shamt;
			K_SHR:   alu = opa >> shamt;
			K_MOVI:  alu = DATA_W'(op_s2.imm);
			K_SET:   alu = DATA_W'(opa < opb);
			K_EXIT:  alu = op_count_q + opa;
			default: alu = '0;
		endcase
	end

	always_comb begin
		case (op_s2.kind)
			K_LD:    sel_s2 = SEL_LOAD;
			K_CALL:  sel_s2 = SEL_HASH;
			default: sel_s2 = SEL_ALU;
		endcase
	end

	always_comb begin
		case (op_s2.kind) inside
			K_MOV, K_ADD, K_SUB, K_AND, K_OR, K_XOR, K_SHL, K_SHR,
			K_MOVI, K_LD, K_SET, K_CALL: wr_s2 = exec_s2;
			default:                     wr_s2 = 1'b0;
		endcase
	end

	// Address wraps to the memory size, which is a power of two.
	assign mem_addr = opa[AW-1:0] + AW'(op_s2.imm[7:0]);
	assign st_fire  = adv && exec_s2 && (op_s2.kind == K_ST);
	assign ld_fire  = adv && exec_s2 && (op_s2.kind == K_LD);

	// Hash: two 32x32 partial products here, summed in stage 3.
	assign plo = opa[31:0] * HASH_MUL;
	assign phi = opa[63:32] * HASH_MUL;

	assign hash_s3 = plo_s3 + {phi_s3, 32'b0} + DATA_W'(1);

	always_comb begin
		case (sel_s3)
			SEL_LOAD: rf_wdata = mrd_s3;
			SEL_HASH: rf_wdata = hash_s3;
			default:  rf_wdata = alu_s3;
		endcase
	end

	assign rf_we    = adv && valid_s3 && wr_s3;
	assign rf_waddr = rd_s3[RW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			skip_q      <= 1'b0;
			op_count_q  <= '0;
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
		end else begin
			if (adv) begin
				valid_s2    <= pop;
				valid_s3    <= valid_s2;
				out_valid_q <= valid_s3;
			end
			if (adv && valid_s2) begin
				if (skip_q) begin
					skip_q <= 1'b0;
				end else if (op_s2.kind == K_BR && opa[0]) begin
					skip_q <= 1'b1;
				end
			end
			if (adv && exec_s2) begin
				case (op_s2.kind)
					K_EXIT:  op_count_q <= '0;
					K_BAD:   op_count_q <= op_count_q;
					default: op_count_q <= op_count_q + DATA_W'(1);
				endcase
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == MEM_LAST) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (pop) begin
				op_s2 <= head_op;
			end
			wr_s3      <= wr_s2;
			sel_s3     <= sel_s2;
			rd_s3      <= op_s2.rd;
			alu_s3     <= alu;
			plo_s3     <= plo;
			phi_s3     <= phi;
			exited_s3  <= exec_s2 && (op_s2.kind == K_EXIT);
			skipped_s3 <= valid_s2 && skip_q;
			bad_s3     <= exec_s2 && (op_s2.kind == K_BAD);
			out_data_q <= exited_s3 ? alu_s3 : '0;
			out_user_q <= {bad_s3, skipped_s3, exited_s3};
		end
	end

	// Data memory: one write port shared by the clearing pass and stores,
	// one registered read port for loads.
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			dmem[clr_addr_q] <= '0;
		end else if (st_fire) begin
			dmem[mem_addr] <= opb;
		end
		if (ld_fire) begin
			mrd_s3 <= dmem[mem_addr];
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = out_data_q;
	assign res_user  = out_user_q;
	assign busy      = clr_busy_q;

endmodule

// File: hdl/rmoe_checker.sv
// ----------------------------------------------------------------------------
// rmoe_checker - port checks for the register machine op executor
// Watches the result stream of the top level and is bound to it.
// ----------------------------------------------------------------------------
module rmoe_checker import rmoe_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              m_axis_tvalid,
	input logic              m_axis_tready,
	input logic [DATA_W-1:0] m_axis_tdata,
	input logic [USER_W-1:0] m_axis_tuser
);

	// A result waiting for the sink keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// An op is an exit, a skip or an unknown opcode, never two of them.
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot0(m_axis_tuser))
		else $error("more than one result flag set");

	// Only an exit carries a value.
	a_value_exit: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[USER_EXITED] |-> m_axis_tdata == '0)
		else $error("non-exit result with a value");

	// A skipped op cannot branch, so two skips never follow each other.
	a_no_double_skip: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser[USER_SKIPPED]
			|=> !(m_axis_tvalid && m_axis_tuser[USER_SKIPPED]))
		else $error("two skipped results in a row");

endmodule

bind register_machine_op_executor rmoe_checker u_rmoe_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
